/* design/mf2d_pkg.sv */
// Shared types and constants of the two-dimensional median filter.
package mf2d_pkg;

  localparam int MF2D_MAX_RADIUS = 10;
  localparam int MF2D_MAX_WIDTH  = 1024;
  localparam int MF2D_MAX_HEIGHT = 1024;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    logic       action;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] median;
    logic       last_of_frame;
  } out_item_t;

  // Control of the bit-serial rank selector.
  typedef struct packed {
    logic clear;
    logic sample;
    logic decide;
  } rank_ctrl_t;

endpackage

/* design/mf2d_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mf2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/mf2d_rank.sv */
// Bit-serial radix selector: finds the element of rank floor(n/2), one bit plane per pass.
module mf2d_rank #(
  parameter int MAX_RADIUS = mf2d_pkg::MF2D_MAX_RADIUS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mf2d_pkg::rank_ctrl_t ctrl_i,
  input  logic [7:0]           data_i,
  output logic [7:0]           median_o,
  output logic                 last_pass_o
);
  import mf2d_pkg::*;

  localparam int NMAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int NW   = $clog2(NMAX + 1);

  logic [7:0]    prefix_q, prefix_d;
  logic [2:0]    bit_q, bit_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] k_q, k_d;
  logic          first_q, first_d;
  logic [7:0]    hi_mask;
  logic          match;
  logic [NW-1:0] k_cur;

  // An element counts when it agrees with the decided upper bits and has a zero here.
  always_comb begin
    hi_mask = 8'hFF << (4'(bit_q) + 4'd1);
    match   = (((data_i ^ prefix_q) & hi_mask) == 8'd0) && !data_i[bit_q];
    k_cur   = first_q ? (n_q >> 1) : k_q;
  end

  // Counting during a pass and the decision at its end.
  always_comb begin
    prefix_d = prefix_q;
    bit_d    = bit_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    k_d      = k_q;
    first_d  = first_q;
    if (ctrl_i.clear) begin
      prefix_d = 8'd0;
      bit_d    = 3'd7;
      cnt_d    = '0;
      n_d      = '0;
      first_d  = 1'b1;
    end else if (ctrl_i.sample) begin
      if (match) begin
        cnt_d = cnt_q + NW'(1);
      end
      if (first_q) begin
        n_d = n_q + NW'(1);
      end
    end else if (ctrl_i.decide) begin
      if (cnt_q > k_cur) begin
        k_d = k_cur;
      end else begin
        k_d = k_cur - cnt_q;
        prefix_d[bit_q] = 1'b1;
      end
      bit_d   = bit_q - 3'd1;
      cnt_d   = '0;
      first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q   <= 3'd7;
      cnt_q   <= '0;
      n_q     <= '0;
      first_q <= 1'b1;
    end else begin
      bit_q   <= bit_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prefix_q <= prefix_d;
    k_q      <= k_d;
  end

  assign median_o    = prefix_q;
  assign last_pass_o = (bit_q == 3'd0);

endmodule

/* design/median_filter_2d_unit.sv */
// Top level of the streaming two-dimensional median filter.
//
// Pixels of one frame enter in raster order on the input channel (valid and
// stall); each transfer carries an action bit and an 8-bit gray value. Results
// leave on the output channel in raster order, each the median of the square
// window of side 2*radius+1 clipped to the image, lagging the input by
// radius*width+radius items. Flush items after the last pixel drain the rest,
// and the final result of the frame carries last_of_frame.
// An item that yields a result passes through setup, a step back over the d <= radius
// window rows above the output pixel to the window corner, eight bit-plane passes over
// the clipped window of n pixels through the single read port of the pixel store, and
// the load of the result into the output register. Items without a result do not stall
// the input. The input stalls while an item is in work; a finished result sits in an
// output register, and when the receiver stalls the block holds the next result until
// the register is taken.
// Reset restores width 1024, height 1024, radius 10 and starts a new frame;
// the pixel store is not cleared, since only pixels of the current frame are
// read. Register writes on the APB port restart the frame.
module median_filter_2d_unit #(
  parameter int MAX_RADIUS = mf2d_pkg::MF2D_MAX_RADIUS,
  parameter int MAX_WIDTH  = mf2d_pkg::MF2D_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf2d_pkg::MF2D_MAX_HEIGHT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mf2d_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mf2d_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mf2d_pkg::*;

  localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int IW    = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                + MAX_RADIUS + 2);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_BACK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DEC   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [10:0]   width_q, height_q;
  logic [3:0]    radius_q;
  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [RW-1:0] r_eff;
  logic [IW-1:0] lag;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [HW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [AW-1:0] p_in_q, p_in_d, p_out_q, p_out_d;
  logic [IW-1:0] items_q, items_d, items_inc;

  logic [HW-1:0] r0_q, r0_d, r1_q, r1_d, y_q, y_d;
  logic [CW-1:0] c0_q, c0_d, c1_q, c1_d, x_q, x_d;
  logic [RW-1:0] dy_q, dy_d;
  logic [AW-1:0] a_q, a_d, base_q, base_d, start_q, start_d;
  logic          rd_v_q;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_data_q, out_data_d;

  logic          cfg_wr, cfg_restart, in_acc, frame_open, is_last, out_free;
  logic [HW-1:0] r0_c, r1_c;
  logic [CW-1:0] c0_c, c1_c;
  logic [HW:0]   row_sum;
  logic [CW:0]   col_sum;
  logic [AW-1:0] sub_amt, back_next, row_next, a_inc;
  logic [AW:0]   row_sum_a;
  logic [RW-1:0] dx;
  logic [7:0]    rdata;
  logic [7:0]    median;
  logic          last_pass;
  rank_ctrl_t    rctrl;

  // Configuration port: registers at byte addresses 0, 4 and 8.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  // Only a write to one of the three registers restarts the frame.
  assign cfg_restart = cfg_wr && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT ||
                                  paddr[3:2] == REG_RADIUS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 11'd1024;
      radius_q <= 4'd10;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH:  width_q  <= pwdata[10:0];
        REG_HEIGHT: height_q <= pwdata[10:0];
        REG_RADIUS: radius_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {21'd0, width_q};
      REG_HEIGHT: prdata = {21'd0, height_q};
      REG_RADIUS: prdata = {28'd0, radius_q};
      default:    prdata = 32'd0;
    endcase
  end

  // Effective geometry after clamping to the supported range.
  always_comb begin
    if (width_q == 11'd0) w_eff = CW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_q);
    if (height_q == 11'd0) h_eff = HW'(1);
    else if (32'(height_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(height_q);
    if (32'(radius_q) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(radius_q);
    lag = IW'(r_eff) * IW'(w_eff) + IW'(r_eff);
  end

  // Window bounds around the current output pixel, clipped to the image.
  always_comb begin
    r0_c    = (out_row_q >= HW'(r_eff)) ? out_row_q - HW'(r_eff) : '0;
    row_sum = {1'b0, out_row_q} + (HW+1)'(r_eff);
    r1_c    = (row_sum < (HW+1)'(h_eff)) ? row_sum[HW-1:0] : h_eff - HW'(1);
    c0_c    = (out_col_q >= CW'(r_eff)) ? out_col_q - CW'(r_eff) : '0;
    col_sum = {1'b0, out_col_q} + (CW+1)'(r_eff);
    c1_c    = (col_sum < (CW+1)'(w_eff)) ? col_sum[CW-1:0] : w_eff - CW'(1);
  end

  // Address arithmetic in the circular store: step back, next row, next column.
  always_comb begin
    dx        = RW'(out_col_q - c0_q);
    sub_amt   = (dy_q != '0) ? AW'(w_eff) : AW'(dx);
    back_next = (a_q >= sub_amt) ? a_q - sub_amt
                : AW'((AW+1)'(a_q) + (AW+1)'(DEPTH) - (AW+1)'(sub_amt));
    row_sum_a = (AW+1)'(base_q) + (AW+1)'(w_eff);
    row_next  = (row_sum_a >= (AW+1)'(DEPTH)) ? AW'(row_sum_a - (AW+1)'(DEPTH))
                : row_sum_a[AW-1:0];
    a_inc     = (a_q == AW'(DEPTH - 1)) ? '0 : a_q + AW'(1);
  end

  assign frame_open = (in_row_q < h_eff);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign items_inc  = items_q + IW'(1);
  assign is_last    = (out_row_q == h_eff - HW'(1)) && (out_col_q == w_eff - CW'(1));
  assign out_free   = !out_valid_q || !out_stall_i;

  // Item sequencer.
  always_comb begin
    state_d     = state_q;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    p_in_d      = p_in_q;
    items_d     = items_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    p_out_d     = p_out_q;
    r0_d        = r0_q;
    r1_d        = r1_q;
    c0_d        = c0_q;
    c1_d        = c1_q;
    dy_d        = dy_q;
    a_d         = a_q;
    base_d      = base_q;
    start_d     = start_q;
    x_d         = x_q;
    y_d         = y_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    rctrl       = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc && !(frame_open && in_data_i.action)) begin
          if (frame_open) begin
            p_in_d = (p_in_q == AW'(DEPTH - 1)) ? '0 : p_in_q + AW'(1);
            if (in_col_q + CW'(1) >= w_eff) begin
              in_col_d = '0;
              in_row_d = in_row_q + HW'(1);
            end else begin
              in_col_d = in_col_q + CW'(1);
            end
          end
          items_d = items_inc;
          if (!(items_inc <= lag || out_row_q >= h_eff)) begin
            state_d = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        rctrl.clear = 1'b1;
        r0_d    = r0_c;
        r1_d    = r1_c;
        c0_d    = c0_c;
        c1_d    = c1_c;
        dy_d    = RW'(out_row_q - r0_c);
        a_d     = p_out_q;
        state_d = S_BACK;
      end
      S_BACK: begin
        a_d = back_next;
        if (dy_q != '0) begin
          dy_d = dy_q - RW'(1);
        end else begin
          base_d  = back_next;
          start_d = back_next;
          x_d     = c0_q;
          y_d     = r0_q;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (x_q == c1_q) begin
          if (y_q == r1_q) begin
            state_d = S_WAIT;
          end else begin
            y_d    = y_q + HW'(1);
            x_d    = c0_q;
            base_d = row_next;
            a_d    = row_next;
          end
        end else begin
          x_d = x_q + CW'(1);
          a_d = a_inc;
        end
      end
      S_WAIT: begin
        state_d = S_DEC;
      end
      S_DEC: begin
        rctrl.decide = 1'b1;
        if (last_pass) begin
          state_d = S_OUT;
        end else begin
          a_d     = start_q;
          base_d  = start_q;
          x_d     = c0_q;
          y_d     = r0_q;
          state_d = S_SCAN;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_data_d.median        = median;
          out_data_d.last_of_frame = is_last;
          state_d                  = S_IDLE;
          if (is_last) begin
            in_col_d  = '0;
            in_row_d  = '0;
            p_in_d    = '0;
            items_d   = '0;
            out_col_d = '0;
            out_row_d = '0;
            p_out_d   = '0;
          end else begin
            p_out_d = (p_out_q == AW'(DEPTH - 1)) ? '0 : p_out_q + AW'(1);
            if (out_col_q + CW'(1) >= w_eff) begin
              out_col_d = '0;
              out_row_d = out_row_q + HW'(1);
            end else begin
              out_col_d = out_col_q + CW'(1);
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A register write starts a new frame.
    if (cfg_restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      p_in_d    = '0;
      items_d   = '0;
      out_col_d = '0;
      out_row_d = '0;
      p_out_d   = '0;
    end

    rctrl.sample = rd_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_col_q    <= '0;
      in_row_q    <= '0;
      p_in_q      <= '0;
      items_q     <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      p_out_q     <= '0;
      dy_q        <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      p_in_q      <= p_in_d;
      items_q     <= items_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      p_out_q     <= p_out_d;
      dy_q        <= dy_d;
      rd_v_q      <= (state_q == S_SCAN);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q       <= r0_d;
    r1_q       <= r1_d;
    c0_q       <= c0_d;
    c1_q       <= c1_d;
    a_q        <= a_d;
    base_q     <= base_d;
    start_q    <= start_d;
    x_q        <= x_d;
    y_q        <= y_d;
    out_data_q <= out_data_d;
  end

  // Pixel store: written on accepted pixels, read while scanning the window.
  mf2d_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && frame_open && !in_data_i.action),
    .waddr_i (p_in_q),
    .wdata_i (in_data_i.pixel),
    .raddr_i (a_q),
    .rdata_o (rdata)
  );

  mf2d_rank #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_rank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (rctrl),
    .data_i      (rdata),
    .median_o    (median),
    .last_pass_o (last_pass)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* design/mf2d_checker.sv */
// Port-level checker of the median filter and its binding to the top level.
module mf2d_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input mf2d_pkg::out_item_t out_data_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic                pready
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // A new result appears only after the input was held off for its work.
  a_rise_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without computation time");

  // No result is raised in the cycle right after an input transfer.
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && !in_stall_o))
    else $error("result raised directly after a transfer");

  // The register port never waits.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("configuration port not ready");

endmodule

bind median_filter_2d_unit mf2d_checker u_mf2d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pready      (pready)
);
